FILE: hw/rtl/ihc_pkg.sv
// Shared types and constants of the IP receive header classifier.
`timescale 1ns / 1ps
`default_nettype none

package ihc_pkg;

  localparam int HDR_DEPTH  = 40;
  localparam int POS_W      = 6;
  localparam int V4_LEN     = 20;
  localparam int V6_LEN     = 40;
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam logic [7:0]  V4_FIRST  = 8'h45;
  localparam logic [15:0] SUM_INIT  = 16'hffff;
  localparam logic [3:0]  VER_V4    = 4'h4;
  localparam logic [3:0]  VER_V6    = 4'h6;
  localparam logic [12:0] FRAG_MASK = 13'h1fff;

  localparam logic [2:0] ST_ACCEPT    = 3'd0;
  localparam logic [2:0] ST_BAD_VER   = 3'd1;
  localparam logic [2:0] ST_SHORT     = 3'd2;
  localparam logic [2:0] ST_BAD_IHL   = 3'd3;
  localparam logic [2:0] ST_BAD_SUM   = 3'd4;
  localparam logic [2:0] ST_HOP_EXP   = 3'd5;
  localparam logic [2:0] ST_FRAGMENT  = 3'd6;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  ip_version;
    logic [7:0]  protocol;
    logic [7:0]  hop_left;
    logic [15:0] payload_len;
    logic [27:0] flow_info;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
  } verdict_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ihc_front.sv
// Byte capture, header checksum and packet classification.
`timescale 1ns / 1ps
`default_nettype none

module ihc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_last_byte,
  input  logic             q_full,
  output logic             q_push,
  output ihc_pkg::verdict_t q_data
);
  import ihc_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       prev_r;
  logic [7:0]       hdr_r [HDR_DEPTH];
  logic [7:0]       hb [HDR_DEPTH];
  logic             accept;
  logic             store;
  logic             add_word;
  logic [16:0]      s17;
  logic [15:0]      sum_fin;
  logic [POS_W-1:0] len;
  logic [15:0]      ff;
  logic [15:0]      tot;
  verdict_t         v;

  always_comb begin
    for (int i = 0; i < HDR_DEPTH; i++) begin
      hb[i] = (pos_r == POS_W'(i)) ? in_data_byte : hdr_r[i];
    end
  end

  always_comb begin
    accept   = in_valid && !q_full;
    store    = pos_r < POS_W'(HDR_DEPTH);
    add_word = store && (pos_r < POS_W'(V4_LEN)) && pos_r[0];
    s17      = {1'b0, sum_r} + {1'b0, prev_r, in_data_byte};
    if (add_word) begin
      sum_fin = s17[16] ? (s17[15:0] + 16'd1) : s17[15:0];
    end else begin
      sum_fin = sum_r;
    end
    len = store ? (pos_r + POS_W'(1)) : pos_r;
    if (in_last_byte) begin
      pos_nxt = '0;
      sum_nxt = SUM_INIT;
    end else begin
      pos_nxt = len;
      sum_nxt = sum_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= SUM_INIT;
    end else if (accept) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store) begin
      hdr_r[pos_r] <= in_data_byte;
    end
    if (accept && !pos_r[0]) begin
      prev_r <= in_data_byte;
    end
  end

  always_comb begin
    v            = '0;
    v.ip_version = hb[0][7:4];
    ff           = {hb[6], hb[7]};
    tot          = {hb[2], hb[3]};
    if (v.ip_version == VER_V4) begin
      priority if (len < POS_W'(V4_LEN)) begin
        v.status = ST_SHORT;
      end else if (hb[0] != V4_FIRST) begin
        v.status = ST_BAD_IHL;
      end else if (sum_fin != SUM_INIT) begin
        v.status = ST_BAD_SUM;
      end else if (hb[8] <= 8'd1) begin
        v.status = ST_HOP_EXP;
      end else if (ff[13] || ((ff[12:0] & FRAG_MASK) != 13'd0)) begin
        v.status = ST_FRAGMENT;
      end else begin
        v.status      = ST_ACCEPT;
        v.protocol    = hb[9];
        v.hop_left    = hb[8] - 8'd1;
        v.payload_len = (tot >= 16'(V4_LEN)) ? (tot - 16'(V4_LEN)) : 16'd0;
        v.src_lo      = {32'd0, hb[12], hb[13], hb[14], hb[15]};
        v.dst_lo      = {32'd0, hb[16], hb[17], hb[18], hb[19]};
      end
    end else if (v.ip_version == VER_V6) begin
      priority if (len < POS_W'(V6_LEN)) begin
        v.status = ST_SHORT;
      end else if (hb[7] <= 8'd1) begin
        v.status = ST_HOP_EXP;
      end else begin
        v.status      = ST_ACCEPT;
        v.protocol    = hb[6];
        v.hop_left    = hb[7] - 8'd1;
        v.payload_len = {hb[4], hb[5]};
        v.flow_info   = {hb[0][3:0], hb[1], hb[2], hb[3]};
        v.src_hi      = {hb[8], hb[9], hb[10], hb[11], hb[12], hb[13], hb[14], hb[15]};
        v.src_lo      = {hb[16], hb[17], hb[18], hb[19], hb[20], hb[21], hb[22], hb[23]};
        v.dst_hi      = {hb[24], hb[25], hb[26], hb[27], hb[28], hb[29], hb[30], hb[31]};
        v.dst_lo      = {hb[32], hb[33], hb[34], hb[35], hb[36], hb[37], hb[38], hb[39]};
      end
    end else begin
      v.status = ST_BAD_VER;
    end
  end

  assign in_stall = q_full;
  assign q_push   = accept && in_last_byte;
  assign q_data   = v;

endmodule

`default_nettype wire

FILE: hw/rtl/ihc_fifo.sv
// Short verdict queue between the classifier and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module ihc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ihc_pkg::verdict_t push_data,
  input  logic              pop,
  output ihc_pkg::verdict_t pop_data,
  output logic              full,
  output logic              empty
);
  import ihc_pkg::*;

  verdict_t         mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    full       = count_r == (PTR_W + 1)'(FIFO_DEPTH);
    empty      = count_r == '0;
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = do_push ? (wr_ptr_r + PTR_W'(1)) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? (rd_ptr_r + PTR_W'(1)) : rd_ptr_r;
    count_nxt  = count_r + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
    pop_data   = mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ihc_back.sv
// Verdict counters and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none

module ihc_back #(
  parameter int COUNT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  ihc_pkg::verdict_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output ihc_pkg::verdict_t out_verdict,
  output logic [31:0]       out_accepted_count,
  output logic [31:0]       out_dropped_count
);
  import ihc_pkg::*;

  logic [COUNT_BITS-1:0] acc_r, acc_nxt;
  logic [COUNT_BITS-1:0] drop_r, drop_nxt;
  logic                  out_valid_r, out_valid_nxt;
  verdict_t              verdict_r;
  logic [31:0]           acc_out_r;
  logic [31:0]           drop_out_r;
  logic                  load;

  always_comb begin
    load     = !q_empty && (!out_valid_r || !out_stall);
    acc_nxt  = acc_r;
    drop_nxt = drop_r;
    if (load) begin
      if (q_data.status == ST_ACCEPT) begin
        acc_nxt = acc_r + COUNT_BITS'(1);
      end else begin
        drop_nxt = drop_r + COUNT_BITS'(1);
      end
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      drop_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict_r  <= q_data;
      acc_out_r  <= 32'(acc_nxt);
      drop_out_r <= 32'(drop_nxt);
    end
  end

  assign q_pop              = load;
  assign out_valid          = out_valid_r;
  assign out_verdict        = verdict_r;
  assign out_accepted_count = acc_out_r;
  assign out_dropped_count  = drop_out_r;

endmodule

`default_nettype wire

FILE: hw/rtl/ip_receive_header_classifier_core.sv
// Top level of the IP receive header classifier.
// The input channel takes one packet byte per cycle (in_data_byte) while
// in_stall is low, with in_last_byte marking the final byte of a packet.
// The block checks the IPv4 or IPv6 header, keeps a running header
// checksum and gives one verdict item on the result channel for every
// packet, with the header fields of an accepted packet and running
// accepted and dropped counts. Throughput is one byte per cycle while
// in_stall is low, and up to one verdict per cycle without out_stall.
// Verdicts pass the two-entry verdict queue and the output register.
// Only the last byte of a packet needs a queue slot; in_stall rises when
// the queue is full, which happens only while out_stall holds results.
// A stalled result holds its value until it is taken.
// After reset the byte position and checksum restart, both counters are
// zero and no result is pending; the first byte accepted starts a packet.
`timescale 1ns / 1ps
`default_nettype none

module ip_receive_header_classifier_core #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_ip_version,
  output logic [7:0]  out_protocol,
  output logic [7:0]  out_hop_left,
  output logic [15:0] out_payload_len,
  output logic [27:0] out_flow_info,
  output logic [63:0] out_src_hi,
  output logic [63:0] out_src_lo,
  output logic [63:0] out_dst_hi,
  output logic [63:0] out_dst_lo,
  output logic [31:0] out_accepted_count,
  output logic [31:0] out_dropped_count
);
  import ihc_pkg::*;

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  verdict_t q_in;
  verdict_t q_out;
  verdict_t res;

  ihc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  ihc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  ihc_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_data             (q_out),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_verdict        (res),
    .out_accepted_count (out_accepted_count),
    .out_dropped_count  (out_dropped_count)
  );

  assign out_status      = res.status;
  assign out_ip_version  = res.ip_version;
  assign out_protocol    = res.protocol;
  assign out_hop_left    = res.hop_left;
  assign out_payload_len = res.payload_len;
  assign out_flow_info   = res.flow_info;
  assign out_src_hi      = res.src_hi;
  assign out_src_lo      = res.src_lo;
  assign out_dst_hi      = res.dst_hi;
  assign out_dst_lo      = res.dst_lo;

endmodule

`default_nettype wire

FILE: test/tb_ip_receive_header_classifier_core.sv
// Self-checking testbench of the IP receive header classifier core with directed and randomized packets.
`timescale 1ns / 1ps

module tb_ip_receive_header_classifier_core;
  import ihc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_BYTES  = 1150;
  localparam int RAND_PKTS   = 60;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } byte_item_t;

  typedef struct packed {
    verdict_t    v;
    logic [31:0] acc;
    logic [31:0] drop;
  } verdict_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [3:0]  out_ip_version;
  logic [7:0]  out_protocol;
  logic [7:0]  out_hop_left;
  logic [15:0] out_payload_len;
  logic [27:0] out_flow_info;
  logic [63:0] out_src_hi;
  logic [63:0] out_src_lo;
  logic [63:0] out_dst_hi;
  logic [63:0] out_dst_lo;
  logic [31:0] out_accepted_count;
  logic [31:0] out_dropped_count;

  byte_item_t   byte_q[$];
  verdict_rec_t verdict_q[$];
  logic [7:0]   pkt[$];
  int           bytes_queued = 0;
  int           pkts_queued = 0;
  int           errors = 0;
  int           cycles = 0;
  int           drv_gap = 0;
  int           ostall_cnt = 0;
  logic         in_acc = 1'b0;
  logic         out_acc = 1'b0;
  logic         calm = 1'b0;

  // Predictor state.
  logic [5:0]   pos = '0;
  logic [7:0]   hdr [HDR_DEPTH];
  logic [16:0]  chk = {1'b0, SUM_INIT};
  logic [31:0]  acc_total = '0;
  logic [31:0]  drop_total = '0;

  ip_receive_header_classifier_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_ip_version    (out_ip_version),
    .out_protocol      (out_protocol),
    .out_hop_left      (out_hop_left),
    .out_payload_len   (out_payload_len),
    .out_flow_info     (out_flow_info),
    .out_src_hi        (out_src_hi),
    .out_src_lo        (out_src_lo),
    .out_dst_hi        (out_dst_hi),
    .out_dst_lo        (out_dst_lo),
    .out_accepted_count(out_accepted_count),
    .out_dropped_count (out_dropped_count)
  );

  always #1 clk = ~clk;

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [63:0] hdr_be(input int first, input int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v = {v[55:0], hdr[first + i]};
    return v;
  endfunction

  task automatic classify_byte(input logic [7:0] b, input logic is_last);
    verdict_rec_t r;
    logic [3:0]   ver;
    logic [7:0]   hop;
    logic [15:0]  ff;
    logic [15:0]  tot;
    if (pos < HDR_DEPTH) begin
      hdr[pos] = b;
      if (pos < V4_LEN && pos[0]) begin
        chk = chk + {hdr[pos - 1], b};
        if (chk > 17'h0ffff) chk = chk - 17'h0ffff;
      end
      pos = pos + 1'b1;
    end
    if (is_last) begin
      r = '0;
      ver = hdr[0][7:4];
      r.v.ip_version = ver;
      r.v.status = ST_ACCEPT;
      if (ver == VER_V4) begin
        if (pos < V4_LEN) begin
          r.v.status = ST_SHORT;
        end else if (hdr[0] != V4_FIRST) begin
          r.v.status = ST_BAD_IHL;
        end else if (chk[15:0] != SUM_INIT) begin
          r.v.status = ST_BAD_SUM;
        end else begin
          hop = hdr[8];
          ff = 16'(hdr_be(6, 2));
          if (hop != 0) hop = hop - 1'b1;
          if (hop == 0) begin
            r.v.status = ST_HOP_EXP;
          end else if (ff[13] || (ff[12:0] & FRAG_MASK) != 0) begin
            r.v.status = ST_FRAGMENT;
          end else begin
            tot = 16'(hdr_be(2, 2));
            r.v.protocol = hdr[9];
            r.v.hop_left = hop;
            r.v.payload_len = (tot >= V4_LEN) ? 16'(tot - V4_LEN) : 16'd0;
            r.v.src_lo = hdr_be(12, 4);
            r.v.dst_lo = hdr_be(16, 4);
          end
        end
      end else if (ver == VER_V6) begin
        if (pos < V6_LEN) begin
          r.v.status = ST_SHORT;
        end else begin
          hop = hdr[7];
          if (hop != 0) hop = hop - 1'b1;
          if (hop == 0) begin
            r.v.status = ST_HOP_EXP;
          end else begin
            r.v.protocol = hdr[6];
            r.v.hop_left = hop;
            r.v.payload_len = 16'(hdr_be(4, 2));
            r.v.flow_info = {hdr[0][3:0], hdr[1], hdr[2], hdr[3]};
            r.v.src_hi = hdr_be(8, 8);
            r.v.src_lo = hdr_be(16, 8);
            r.v.dst_hi = hdr_be(24, 8);
            r.v.dst_lo = hdr_be(32, 8);
          end
        end
      end else begin
        r.v.status = ST_BAD_VER;
      end
      if (r.v.status == ST_ACCEPT) acc_total = acc_total + 1'b1;
      else drop_total = drop_total + 1'b1;
      r.acc = acc_total;
      r.drop = drop_total;
      verdict_q.push_back(r);
      pos = '0;
      chk = {1'b0, SUM_INIT};
    end
  endtask

  task automatic build_v4(input logic [7:0] b0, input logic [7:0] proto, input logic [7:0] ttl,
                          input logic [15:0] tot, input logic [15:0] ff,
                          input logic [31:0] src, input logic [31:0] dst);
    logic [159:0] h;
    logic [16:0]  s;
    h = {b0, 8'($urandom_range(0, 255)), tot, 16'($urandom), ff, ttl, proto, 16'h0000,
         src, dst};
    pkt = {};
    for (int i = 0; i < V4_LEN; i++) pkt.push_back(h[159 - 8 * i -: 8]);
    s = {1'b0, SUM_INIT};
    for (int i = 0; i < V4_LEN; i += 2) begin
      s = s + {pkt[i], pkt[i + 1]};
      if (s > 17'h0ffff) s = s - 17'h0ffff;
    end
    pkt[10] = ~s[15:8];
    pkt[11] = ~s[7:0];
  endtask

  task automatic build_v6(input logic [27:0] flow, input logic [15:0] plen, input logic [7:0] nh,
                          input logic [7:0] hop, input logic [127:0] src,
                          input logic [127:0] dst);
    logic [319:0] h;
    h = {VER_V6, flow, plen, nh, hop, src, dst};
    pkt = {};
    for (int i = 0; i < V6_LEN; i++) pkt.push_back(h[319 - 8 * i -: 8]);
  endtask

  task automatic add_payload(input int n);
    for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_pkt(input int n);
    byte_item_t it;
    for (int i = 0; i < n; i++) begin
      it.data = pkt[i];
      it.is_last = (i == n - 1);
      byte_q.push_back(it);
    end
    bytes_queued += n;
    pkts_queued++;
  endtask

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Handshake sampling, prediction and checking at the rising edge.
  always @(posedge clk) begin : mon
    verdict_rec_t got;
    verdict_rec_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[ip_receive_header_classifier_core] ERROR");
      $finish;
    end else begin
      in_acc = rst_n && in_valid && !in_stall;
      out_acc = rst_n && out_valid && !out_stall;
      if (out_acc) begin
        got = {out_status, out_ip_version, out_protocol, out_hop_left, out_payload_len,
               out_flow_info, out_src_hi, out_src_lo, out_dst_hi, out_dst_lo,
               out_accepted_count, out_dropped_count};
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected verdict item, status %0d.", out_status);
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("Mismatch exp/act: status %0d/%0d ver %h/%h proto %h/%h hop %h/%h len %h/%h",
                       want.v.status, got.v.status, want.v.ip_version, got.v.ip_version,
                       want.v.protocol, got.v.protocol, want.v.hop_left, got.v.hop_left,
                       want.v.payload_len, got.v.payload_len);
              $display("  flow %h/%h src %h%h/%h%h dst %h%h/%h%h acc %0d/%0d drop %0d/%0d",
                       want.v.flow_info, got.v.flow_info, want.v.src_hi, want.v.src_lo,
                       got.v.src_hi, got.v.src_lo, want.v.dst_hi, want.v.dst_lo,
                       got.v.dst_hi, got.v.dst_lo, want.acc, got.acc, want.drop, got.drop);
            end
          end
        end
      end
      if (in_acc) begin
        classify_byte(in_data_byte, in_last_byte);
        if ($urandom_range(0, 149) == 0) calm = !calm;
      end
    end
  end

  always @(negedge clk) begin : drv
    byte_item_t it;
    logic       v_next;
    if (rst_n) begin
      if (in_acc) drv_gap = draw_gap();
      v_next = in_valid && !in_acc;
      if (!v_next) begin
        if (drv_gap != 0) begin
          drv_gap--;
        end else if (byte_q.size() != 0) begin
          it = byte_q.pop_front();
          in_data_byte <= it.data;
          in_last_byte <= it.is_last;
          v_next = 1'b1;
        end
      end
      in_valid <= v_next;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_acc) ostall_cnt = draw_gap();
      else if (out_valid && ostall_cnt != 0) ostall_cnt--;
      out_stall <= (ostall_cnt != 0);
    end
  end

  initial begin : stim
    int          kind;
    int          idx;
    int          nib;
    logic [15:0] tot;
    logic [15:0] ff;
    logic [7:0]  ttl;
    logic [7:0]  proto;

    // Directed packets.
    pkt = {8'h00};
    send_pkt(1);
    pkt = {8'hff};
    send_pkt(1);
    pkt = {V4_FIRST};
    send_pkt(1);
    pkt = {8'h6a};
    send_pkt(1);
    build_v4(V4_FIRST, 8'h06, 8'h40, 16'd60, 16'h0000, $urandom, $urandom);
    send_pkt(V4_LEN - 1);
    build_v4(V4_FIRST, 8'h00, 8'h02, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_pkt(pkt.size());
    build_v4(V4_FIRST, 8'hff, 8'hff, 16'hffff, 16'h4000, 32'hffffffff, 32'hffffffff);
    add_payload(5);
    send_pkt(pkt.size());
    build_v4(8'h46, 8'h11, 8'h40, 16'd40, 16'h0000, $urandom, $urandom);
    send_pkt(pkt.size());
    build_v4(V4_FIRST, 8'h11, 8'h40, 16'd40, 16'h0000, $urandom, $urandom);
    pkt[15] = pkt[15] ^ 8'h01;
    send_pkt(pkt.size());
    build_v4(V4_FIRST, 8'h11, 8'h01, 16'd40, 16'h0000, $urandom, $urandom);
    send_pkt(pkt.size());
    build_v4(V4_FIRST, 8'h11, 8'h00, 16'd40, 16'h0000, $urandom, $urandom);
    send_pkt(pkt.size());
    build_v4(V4_FIRST, 8'h11, 8'h40, 16'd40, 16'h2000, $urandom, $urandom);
    send_pkt(pkt.size());
    build_v4(V4_FIRST, 8'h11, 8'h40, 16'd40, 16'h0001, $urandom, $urandom);
    send_pkt(pkt.size());
    build_v4(V4_FIRST, 8'h11, 8'h40, 16'd40, 16'h1fff, $urandom, $urandom);
    send_pkt(pkt.size());
    build_v4(V4_FIRST, 8'h11, 8'h40, 16'd19, 16'h8000, $urandom, $urandom);
    send_pkt(pkt.size());
    build_v4(V4_FIRST, 8'h01, 8'h80, 16'd20, 16'h0000, $urandom, $urandom);
    add_payload(30);
    send_pkt(pkt.size());
    build_v6(28'h0, 16'd0, 8'h3a, 8'h40, rand128(), rand128());
    send_pkt(V6_LEN - 1);
    build_v6(28'hfffffff, 16'hffff, 8'hff, 8'hff, {128{1'b1}}, {128{1'b1}});
    send_pkt(pkt.size());
    build_v6(28'h0, 16'h0000, 8'h00, 8'h02, 128'h0, 128'h0);
    add_payload(10);
    send_pkt(pkt.size());
    build_v6(28'h1234567, 16'd8, 8'h11, 8'h00, rand128(), rand128());
    send_pkt(pkt.size());
    build_v6(28'h7654321, 16'd8, 8'h11, 8'h01, rand128(), rand128());
    send_pkt(pkt.size());

    // Random packets, mostly well formed.
    while (bytes_queued < RAND_BYTES || pkts_queued < RAND_PKTS) begin
      kind = $urandom_range(0, 19);
      tot = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 24)) : 16'($urandom);
      ff = {1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 14'd0};
      ttl = 8'($urandom_range(2, 255));
      proto = 8'($urandom_range(0, 255));
      case (kind)
        0, 1, 2, 3, 4, 5, 6, 19: begin
          build_v4(V4_FIRST, proto, ttl, tot, ff, $urandom, $urandom);
          if (kind == 19) add_payload($urandom_range(20, 40));
          else add_payload(($urandom_range(0, 3) == 0) ? $urandom_range(0, 30)
                                                      : $urandom_range(0, 4));
          send_pkt(pkt.size());
        end
        7: begin
          ff[13] = 1'($urandom_range(0, 1));
          ff[12:0] = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'($urandom);
          if (ff[13:0] == 14'd0) ff[13] = 1'b1;
          build_v4(V4_FIRST, proto, ttl, tot, ff, $urandom, $urandom);
          add_payload($urandom_range(0, 4));
          send_pkt(pkt.size());
        end
        8: begin
          build_v4(V4_FIRST, proto, ttl, tot, ff, $urandom, $urandom);
          idx = $urandom_range(1, V4_LEN - 1);
          pkt[idx] = pkt[idx] ^ 8'(1 << $urandom_range(0, 7));
          send_pkt(pkt.size());
        end
        9: begin
          build_v4(V4_FIRST, proto, 8'($urandom_range(0, 1)), tot, ff, $urandom, $urandom);
          send_pkt(pkt.size());
        end
        10: begin
          nib = $urandom_range(0, 14);
          if (nib >= 5) nib++;
          build_v4({VER_V4, 4'(nib)}, proto, ttl, tot, ff, $urandom, $urandom);
          send_pkt(pkt.size());
        end
        11: begin
          build_v4(V4_FIRST, proto, ttl, tot, ff, $urandom, $urandom);
          send_pkt($urandom_range(1, V4_LEN - 1));
        end
        12, 13, 14: begin
          build_v6(28'($urandom), 16'($urandom), proto, ttl, rand128(), rand128());
          add_payload($urandom_range(0, 6));
          send_pkt(pkt.size());
        end
        15: begin
          build_v6(28'($urandom), 16'($urandom), proto, ttl, rand128(), rand128());
          send_pkt($urandom_range(1, V6_LEN - 1));
        end
        16: begin
          build_v6(28'($urandom), 16'($urandom), proto, 8'($urandom_range(0, 1)),
                   rand128(), rand128());
          send_pkt(pkt.size());
        end
        17: begin
          nib = $urandom_range(0, 13);
          if (nib >= 4) nib++;
          if (nib >= 6) nib++;
          pkt = {};
          add_payload($urandom_range(1, 45));
          pkt[0][7:4] = 4'(nib);
          send_pkt(pkt.size());
        end
        default: begin
          pkt = {};
          add_payload($urandom_range(1, 50));
          send_pkt(pkt.size());
        end
      endcase
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[ip_receive_header_classifier_core] OK");
    end else begin
      $display("[ip_receive_header_classifier_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ihc_pkg.sv
hw/rtl/ihc_front.sv
hw/rtl/ihc_fifo.sv
hw/rtl/ihc_back.sv
hw/rtl/ip_receive_header_classifier_core.sv
test/tb_ip_receive_header_classifier_core.sv
